>>> hdl/macd_with_extreme_tracking_unit_defines.svh
// Assertion macros for the MACD unit
`ifndef MACD_WITH_EXTREME_TRACKING_UNIT_DEFINES_SVH
`define MACD_WITH_EXTREME_TRACKING_UNIT_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define MACD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("macd: check failed");
// next-cycle implication
`define MACD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("macd: check failed");
`endif

>>> hdl/macd_pkg.sv
`default_nettype none
package macd_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WEIGHT_BITS   = 16;
	localparam int TRACK_LIMIT   = 9999;
	localparam logic [15:0] SHORT_RST  = 16'd10082;
	localparam logic [15:0] LONG_RST   = 16'd4855;
	localparam logic [15:0] SIGNAL_RST = 16'd13107;
	localparam logic [1:0] REG_SHORT  = 2'd0;
	localparam logic [1:0] REG_LONG   = 2'd1;
	localparam logic [1:0] REG_SIGNAL = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_PEAK = 2'd1;
	localparam logic [1:0] KIND_TROUGH = 2'd2;
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;
	// serial multiplier command
	typedef struct packed {
		logic        start;
		logic [49:0] diff;
		logic [15:0] weight;
	} mul_cmd_t;
	typedef struct packed {
		logic        done;
		logic [49:0] delta;
	} mul_rsp_t;
endpackage
`default_nettype wire

>>> hdl/macd_mul.sv
`default_nettype none
// Bit-serial signed x unsigned multiply, floor(diff*w / 2^16), one weight bit a cycle
module macd_mul
	import macd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mul_cmd_t cmd,
	output mul_rsp_t      rsp
);
	localparam int CW = $clog2(WEIGHT_BITS + 1);
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [66:0]   acc_q;
	logic [15:0]   w_q;
	logic [49:0]   d_q;
	logic [66:0]   addend;
	logic [66:0]   acc_next;

	// shift-add from MSB of weight: acc = 2*acc + (w bit ? d : 0)
	always_comb begin
		addend   = w_q[15] ? {{17{d_q[49]}}, d_q} : '0;
		acc_next = {acc_q[65:0], 1'b0} + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(WEIGHT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
			w_q   <= cmd.weight;
			d_q   <= cmd.diff;
		end else if (busy_q) begin
			acc_q <= acc_next;
			w_q   <= {w_q[14:0], 1'b0};
		end
	end

	// arithmetic shift is a floor divide
	assign rsp.done  = busy_q && (cnt_q == CW'(1));
	assign rsp.delta = acc_next[65:16];
endmodule
`default_nettype wire

>>> hdl/macd_with_extreme_tracking_unit.sv
`default_nettype none
// MACD oscillator with histogram extreme tracking.
// Input channel (in_valid/in_ready) carries opcode and close, high and low
// prices in unsigned Q16.16; output channel (out_valid/out_ready) carries one
// result beat per input beat: dif, dea, histogram, running max/min and the
// closed extreme (kind, level, price).
// Weights are written over the APB port at 0x0, 0x4, 0x8 (Q0.16).
// A price sample runs three EMA updates in turn through one bit-serial
// multiplier (ST_FAST, ST_SLOW, ST_SIG), with ST_SIGI between the second
// and third to form the signal difference, then ST_TRK and ST_OUT. A new
// item is taken only in ST_IDLE. The seeding sample goes to ST_TRK and then
// ST_OUT, a clear beat straight to ST_OUT. One item is in work at a time.
// The result sits in an output register: a stalled receiver holds it, and
// the next item is accepted while it waits but cannot finish until taken.
// Reset loads the default weights, clears the EMAs and the extreme tracker
// and sets the running max/min to -9999 and +9999. No clearing pass.
module macd_with_extreme_tracking_unit
	import macd_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [31:0] close_price,
	input  wire logic [31:0] high_price,
	input  wire logic [31:0] low_price,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [32:0] dif_value,
	output logic signed [32:0] dea_value,
	output logic signed [34:0] histogram,
	output logic signed [32:0] running_max,
	output logic signed [32:0] running_min,
	output logic        [1:0]  closed_kind,
	output logic signed [34:0] closed_level,
	output logic        [31:0] closed_price
);
	`include "macd_with_extreme_tracking_unit_defines.svh"

	localparam logic signed [32:0] LIM = 33'(TRACK_LIMIT) <<< FRAC_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FAST = 3'd1;
	localparam logic [2:0] ST_SLOW = 3'd2;
	localparam logic [2:0] ST_SIG  = 3'd3;
	localparam logic [2:0] ST_TRK  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;
	localparam logic [2:0] ST_SIGI = 3'd6;

	logic [2:0]  state_q;
	logic [15:0] w_short_q, w_long_q, w_sig_q;
	logic signed [47:0] fast_q, slow_q;
	logic signed [49:0] sig_q;
	logic        seeded_q;
	logic signed [32:0] max_q, min_q;
	logic        ext_v_q;
	logic signed [34:0] ext_lvl_q;
	logic [31:0] ext_price_q;
	logic [31:0] close_q, high_q, low_q;
	mul_cmd_t    mcmd;
	mul_rsp_t    mrsp;

	// closed extreme of the item in work
	logic [1:0]  c_kind_q;
	logic signed [34:0] c_clvl_q;
	logic [31:0] c_cpr_q;

	// result registers
	logic signed [32:0] r_dif_q, r_dea_q, r_max_q, r_min_q;
	logic signed [34:0] r_hist_q, r_clvl_q;
	logic [1:0]  r_kind_q;
	logic [31:0] r_cpr_q;
	logic        ov_q;

	macd_mul u_mul (.clk(clk), .arst_n(arst_n), .cmd(mcmd), .rsp(mrsp));

	// APB register file
	logic wr_en;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_short_q <= SHORT_RST;
			w_long_q  <= LONG_RST;
			w_sig_q   <= SIGNAL_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_SHORT:  w_short_q <= pwdata[15:0];
				REG_LONG:   w_long_q  <= pwdata[15:0];
				REG_SIGNAL: w_sig_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			REG_SHORT:  prdata = {16'd0, w_short_q};
			REG_LONG:   prdata = {16'd0, w_long_q};
			REG_SIGNAL: prdata = {16'd0, w_sig_q};
			default:    prdata = '0;
		endcase
	end

	// derived values
	logic signed [49:0] dif_w, close_x;
	logic signed [34:0] hist_w;
	logic signed [32:0] dif33, dea33;
	assign close_x = $signed({18'd0, close_q});
	assign dif_w   = 50'(fast_q) - 50'(slow_q);
	assign dif33   = dif_w[32:0];
	assign dea33   = sig_q[32:0];
	assign hist_w  = (35'(dif33) - 35'(dea33)) <<< 1;

	// multiplier issue
	always_comb begin
		mcmd.start  = 1'b0;
		mcmd.diff   = '0;
		mcmd.weight = '0;
		if (state_q == ST_IDLE && in_valid && opcode == OP_SAMPLE && seeded_q) begin
			mcmd.start  = 1'b1;
			mcmd.diff   = $signed({18'd0, close_price}) - 50'(fast_q);
			mcmd.weight = w_short_q;
		end else if (state_q == ST_FAST && mrsp.done) begin
			mcmd.start  = 1'b1;
			mcmd.diff   = close_x - 50'(slow_q);
			mcmd.weight = w_long_q;
		end else if (state_q == ST_SIGI) begin
			mcmd.start  = 1'b1;
			mcmd.diff   = dif_w - sig_q;
			mcmd.weight = w_sig_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ov_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fast_q <= '0; slow_q <= '0; sig_q <= '0; seeded_q <= 1'b0;
			max_q <= -LIM; min_q <= LIM;
			ext_v_q <= 1'b0; ext_lvl_q <= '0; ext_price_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) begin
					if (opcode == OP_CLEAR) begin
						ext_v_q <= 1'b0; ext_price_q <= '0;
						state_q <= ST_OUT;
					end else if (!seeded_q) begin
						fast_q <= 48'(close_price); slow_q <= 48'(close_price);
						sig_q <= '0; seeded_q <= 1'b1;
						state_q <= ST_TRK;
					end else state_q <= ST_FAST;
				end
				ST_FAST: if (mrsp.done) begin
					fast_q <= fast_q + 48'(mrsp.delta); state_q <= ST_SLOW;
				end
				ST_SLOW: if (mrsp.done) begin
					slow_q <= slow_q + 48'(mrsp.delta); state_q <= ST_SIGI;
				end
				ST_SIGI: state_q <= ST_SIG;
				ST_SIG: if (mrsp.done) begin
					sig_q <= sig_q + mrsp.delta; state_q <= ST_TRK;
				end
				ST_TRK: begin
					// running extremes and histogram tracker
					if ((dif33 > dea33 ? dif33 : dea33) > max_q)
						max_q <= (dif33 > dea33 ? dif33 : dea33);
					if ((dif33 < dea33 ? dif33 : dea33) < min_q)
						min_q <= (dif33 < dea33 ? dif33 : dea33);
					state_q <= ST_OUT;
					if (!ext_v_q) begin
						ext_v_q <= 1'b1; ext_lvl_q <= hist_w; ext_price_q <= close_q;
					end else if (hist_w < 0) begin
						if (ext_lvl_q < 0) begin
							if (ext_lvl_q > hist_w) begin
								ext_lvl_q <= hist_w; ext_price_q <= low_q;
							end
						end else begin
							ext_lvl_q <= hist_w; ext_price_q <= close_q;
						end
					end else begin
						if (ext_lvl_q > 0) begin
							if (ext_lvl_q < hist_w) begin
								ext_lvl_q <= hist_w; ext_price_q <= high_q;
							end
						end else begin
							ext_lvl_q <= hist_w; ext_price_q <= close_q;
						end
					end
				end
				ST_OUT: if (!ov_q || out_ready) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture input beat, closed extreme and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			close_q <= close_price;
			high_q <= high_price; low_q <= low_price;
			c_kind_q <= KIND_NONE; c_clvl_q <= '0; c_cpr_q <= '0;
		end
		if (state_q == ST_TRK && ext_v_q) begin
			if (hist_w < 0 && !(ext_lvl_q < 0)) begin
				c_kind_q <= KIND_PEAK; c_clvl_q <= ext_lvl_q; c_cpr_q <= ext_price_q;
			end else if (!(hist_w < 0) && !(ext_lvl_q > 0)) begin
				c_kind_q <= KIND_TROUGH; c_clvl_q <= ext_lvl_q; c_cpr_q <= ext_price_q;
			end
		end
		if (state_q == ST_OUT && (!ov_q || out_ready)) begin
			r_dif_q <= dif33; r_dea_q <= dea33; r_hist_q <= hist_w;
			r_max_q <= max_q; r_min_q <= min_q;
			r_kind_q <= c_kind_q; r_clvl_q <= c_clvl_q; r_cpr_q <= c_cpr_q;
		end
	end

	assign dif_value    = r_dif_q;
	assign dea_value    = r_dea_q;
	assign histogram    = r_hist_q;
	assign running_max  = r_max_q;
	assign running_min  = r_min_q;
	assign closed_kind  = r_kind_q;
	assign closed_level = r_clvl_q;
	assign closed_price = r_cpr_q;

	// multiplier phases
	logic in_mul;
	assign in_mul = (state_q == ST_FAST) || (state_q == ST_SLOW) || (state_q == ST_SIG);

	`MACD_ASSERT_IMP(a_mul_only_busy, mrsp.done, in_mul)
	`MACD_ASSERT_NXT(a_clear_empties, state_q == ST_IDLE && in_valid && opcode == OP_CLEAR, !ext_v_q)
	`MACD_ASSERT_IMP(a_max_ge_min_seen, seeded_q && state_q == ST_IDLE, max_q >= min_q)
endmodule
`default_nettype wire
